FILE: hdl/ltt_pkg.sv
// ----------------------------------------------------------------------------
// ltt_pkg
// Shared types and constants of the lambda-term tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ltt_pkg;

    localparam int unsigned MAX_CHARS_DEF = 65536;
    localparam int unsigned Q_DEPTH_DEF   = 4;
    localparam logic [15:0] MAX_TOK_RST   = 16'd4096;
    localparam logic [15:0] SAT16         = 16'hFFFF;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_USCR  = 8'h5F;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_UT    = 8'h54;
    localparam logic [7:0] CH_LY    = 8'h79;
    localparam logic [7:0] CH_LP    = 8'h70;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LM    = 8'h6D;
    localparam logic [7:0] CH_LF    = 8'h66;

    typedef enum logic [3:0] {
        K_COLON, K_DOT, K_OPEN, K_CLOSE, K_ARROW, K_PI, K_LAMBDA, K_ATTYPE,
        K_ATTERM, K_ATDEF, K_EQ, K_TYPE, K_VAR, K_END, K_NUMBER
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK, ST_DASH, ST_SLASH, ST_AT, ST_ROOM, ST_CHAR, ST_LONG
    } t_status;

    typedef enum logic [2:0] {
        M_IDLE, M_COMMENT, M_IDENT, M_DASH, M_SLASH, M_ATTYPE, M_ATTERM, M_ATDEF
    } t_mode;

    // word slots: 0 first token or var, 1 start, 2 length, 3 token, 4 end
    typedef struct packed {
        logic [4:0]  mask;
        t_kind       kind0;
        logic [15:0] start;
        logic [15:0] len;
        t_kind       kind3;
        logic [15:0] count;
        t_status     status;
    } t_desc;

endpackage

`default_nettype wire

FILE: hdl/lambda_term_tokenizer.sv
// Words of an accepted byte go through the queue and the output register.
// Throughput: one byte per cycle while the queue is not full and each byte
// yields at most one word; extra words hold the emitter, queue absorbs bursts.
// Reset (synchronous, active low) clears scan state, queue and output stage,
// and sets max_tokens to 4096.
// ----------------------------------------------------------------------------
// lambda_term_tokenizer
// Byte-stream tokenizer for a small typed lambda-calculus language.
// ----------------------------------------------------------------------------
`default_nettype none

module lambda_term_tokenizer #(
    parameter int unsigned MAX_CHARS   = ltt_pkg::MAX_CHARS_DEF,
    parameter int unsigned QUEUE_DEPTH = ltt_pkg::Q_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,   // max_tokens
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] ch
    input  logic        i_s_tuser,     // [0] has_char
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,     // [15:0] word_value, [18:16] status
    output logic [3:0]  o_m_tuser,     // [3:0] word_kind
    output logic        o_m_tlast
);
    import ltt_pkg::*;

    t_desc       w_in_desc, w_head;
    logic        w_push, w_full, w_pop, w_empty;
    logic [3:0]  w_kind;
    logic [15:0] w_value;
    logic [2:0]  w_status;

    ltt_front #(
        .MAX_CHARS (MAX_CHARS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_tvalid),
        .i_ch        (i_s_tdata),
        .i_has_char  (i_s_tuser),
        .i_last      (i_s_tlast),
        .o_ready     (o_s_tready),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_desc      (w_in_desc)
    );

    ltt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_in_desc),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_desc  (w_head)
    );

    ltt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_desc   (w_head),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_kind   (w_kind),
        .o_value  (w_value),
        .o_status (w_status),
        .o_last   (o_m_tlast)
    );

    assign o_m_tuser = w_kind;
    assign o_m_tdata = {5'd0, w_status, w_value};

endmodule

`default_nettype wire

FILE: hdl/ltt_front.sv
// ----------------------------------------------------------------------------
// ltt_front
// Byte scanner: tracks token state and packs the words of each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ltt_front #(
    parameter int unsigned MAX_CHARS = ltt_pkg::MAX_CHARS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,
    input  logic          i_valid,
    input  logic [7:0]    i_ch,
    input  logic          i_has_char,
    input  logic          i_last,
    output logic          o_ready,
    input  logic          i_full,
    output logic          o_push,
    output ltt_pkg::t_desc o_desc
);
    import ltt_pkg::*;

    localparam int unsigned PW = $clog2(MAX_CHARS + 1);
    localparam logic [7:0] TYPE_WORD [4] = '{CH_UT, CH_LY, CH_LP, CH_LE};

    logic [15:0]   r_max;
    t_mode         r_mode, n_mode;
    logic [2:0]    r_step, n_step;
    logic [15:0]   r_start, n_start;
    logic [15:0]   r_len, n_len;
    logic          r_tok, n_tok;
    logic [PW-1:0] r_pos, n_pos;
    logic [15:0]   r_count, n_count;
    t_status       r_err, n_err;
    t_desc         w_desc;
    logic          w_acc;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_QUOTE || c == CH_USCR;
    endfunction

    assign o_ready = !i_full;
    assign w_acc   = i_valid && o_ready;
    assign o_push  = w_acc && (w_desc.mask != 5'd0);
    assign o_desc  = w_desc;

    always_comb begin
        logic        stopped;
        logic        do_start;
        logic        tf;
        t_kind       tk;
        logic [24:0] pos_ext;
        logic [7:0]  c;
        n_mode   = r_mode;
        n_step   = r_step;
        n_start  = r_start;
        n_len    = r_len;
        n_tok    = r_tok;
        n_pos    = r_pos;
        n_count  = r_count;
        n_err    = r_err;
        w_desc   = '0;
        do_start = 1'b0;
        tf       = 1'b0;
        tk       = K_COLON;
        c        = i_ch;
        pos_ext  = 25'(r_pos);
        stopped  = (r_mode == M_IDLE) && (r_count >= r_max);
        if (w_acc && i_has_char && r_err == ST_OK && !stopped) begin
            if (r_pos >= PW'(MAX_CHARS)) begin
                n_err  = ST_LONG;
                n_mode = M_IDLE;
            end else begin
                n_pos = r_pos + 1'b1;
                case (r_mode)
                    M_COMMENT: begin
                        if (c == CH_NL) n_mode = M_IDLE;
                    end
                    M_IDENT: begin
                        if (is_ident(c)) begin
                            if (r_len != SAT16) n_len = r_len + 16'd1;
                            if (r_step < 3'd4) begin
                                if (c != TYPE_WORD[r_step[1:0]]) n_tok = 1'b0;
                                n_step = r_step + 3'd1;
                            end
                        end else begin
                            n_mode = M_IDLE;
                            if (r_len == 16'd4 && r_tok) begin
                                w_desc.mask[0] = 1'b1;
                                w_desc.kind0   = K_TYPE;
                                n_count        = n_count + 16'd1;
                            end else if ({1'b0, r_count} + 17'd3 < {1'b0, r_max}) begin
                                w_desc.mask[2:0] = 3'b111;
                                w_desc.kind0     = K_VAR;
                                w_desc.start     = r_start;
                                w_desc.len       = r_len;
                                n_count          = n_count + 16'd3;
                            end else begin
                                n_err = ST_ROOM;
                            end
                            if (n_err == ST_OK && n_count < r_max) do_start = 1'b1;
                        end
                    end
                    M_DASH: begin
                        if (c == CH_GT) begin
                            tf = 1'b1;
                            tk = K_ARROW;
                        end else begin
                            n_err  = ST_DASH;
                            n_mode = M_IDLE;
                        end
                    end
                    M_SLASH: begin
                        if (c == CH_BSL) begin
                            tf = 1'b1;
                            tk = K_PI;
                        end else begin
                            n_err  = ST_SLASH;
                            n_mode = M_IDLE;
                        end
                    end
                    M_ATTYPE: begin
                        n_err  = ST_AT;
                        n_mode = M_IDLE;
                        case (r_step)
                            3'd0: begin
                                if (c == CH_LT) begin
                                    n_err = ST_OK; n_mode = M_ATTYPE; n_step = 3'd1;
                                end else if (c == CH_LD) begin
                                    n_err = ST_OK; n_mode = M_ATDEF; n_step = 3'd1;
                                end
                            end
                            3'd1: begin
                                if (c == CH_LY) begin
                                    n_err = ST_OK; n_mode = M_ATTYPE; n_step = 3'd2;
                                end else if (c == CH_LE) begin
                                    n_err = ST_OK; n_mode = M_ATTERM; n_step = 3'd2;
                                end
                            end
                            3'd2: begin
                                if (c == CH_LP) begin
                                    n_err = ST_OK; n_mode = M_ATTYPE; n_step = 3'd3;
                                end
                            end
                            default: begin
                                if (c == CH_LE) begin
                                    n_err = ST_OK; tf = 1'b1; tk = K_ATTYPE;
                                end
                            end
                        endcase
                    end
                    M_ATTERM: begin
                        n_err  = ST_AT;
                        n_mode = M_IDLE;
                        if (r_step == 3'd2) begin
                            if (c == CH_LR) begin
                                n_err = ST_OK; n_mode = M_ATTERM; n_step = 3'd3;
                            end
                        end else if (c == CH_LM) begin
                            n_err = ST_OK; tf = 1'b1; tk = K_ATTERM;
                        end
                    end
                    M_ATDEF: begin
                        n_err  = ST_AT;
                        n_mode = M_IDLE;
                        if (r_step == 3'd1) begin
                            if (c == CH_LE) begin
                                n_err = ST_OK; n_mode = M_ATDEF; n_step = 3'd2;
                            end
                        end else if (c == CH_LF) begin
                            n_err = ST_OK; tf = 1'b1; tk = K_ATDEF;
                        end
                    end
                    default: do_start = 1'b1;
                endcase
                if (do_start) begin
                    case (c)
                        CH_COLON: begin tf = 1'b1; tk = K_COLON;  end
                        CH_DOT:   begin tf = 1'b1; tk = K_DOT;    end
                        CH_OPEN:  begin tf = 1'b1; tk = K_OPEN;   end
                        CH_CLOSE: begin tf = 1'b1; tk = K_CLOSE;  end
                        CH_BSL:   begin tf = 1'b1; tk = K_LAMBDA; end
                        CH_EQ:    begin tf = 1'b1; tk = K_EQ;     end
                        CH_SEMI:  n_mode = M_COMMENT;
                        CH_DASH:  n_mode = M_DASH;
                        CH_SLASH: n_mode = M_SLASH;
                        CH_AT: begin
                            n_mode = M_ATTYPE;
                            n_step = 3'd0;
                        end
                        CH_SP, CH_TAB, CH_NL: ;
                        default: begin
                            if (is_letter(c)) begin
                                n_mode  = M_IDENT;
                                n_start = (pos_ext > 25'(SAT16)) ? SAT16 : pos_ext[15:0];
                                n_len   = 16'd1;
                                n_tok   = (c == CH_UT);
                                n_step  = 3'd1;
                            end else begin
                                n_err  = ST_CHAR;
                                n_mode = M_IDLE;
                            end
                        end
                    endcase
                end
                if (tf) begin
                    w_desc.mask[3] = 1'b1;
                    w_desc.kind3   = tk;
                    n_count        = n_count + 16'd1;
                    n_mode         = M_IDLE;
                end
            end
        end
        if (w_acc && i_last) begin
            if (n_err == ST_OK) begin
                case (n_mode)
                    M_IDENT: begin
                        if (n_len == 16'd4 && n_tok) begin
                            w_desc.mask[0] = 1'b1;
                            w_desc.kind0   = K_TYPE;
                            n_count        = n_count + 16'd1;
                        end else if ({1'b0, n_count} + 17'd3 < {1'b0, r_max}) begin
                            w_desc.mask[2:0] = 3'b111;
                            w_desc.kind0     = K_VAR;
                            w_desc.start     = n_start;
                            w_desc.len       = n_len;
                            n_count          = n_count + 16'd3;
                        end else begin
                            n_err = ST_ROOM;
                        end
                    end
                    M_DASH:  n_err = ST_DASH;
                    M_SLASH: n_err = ST_SLASH;
                    M_ATTYPE, M_ATTERM, M_ATDEF: n_err = ST_AT;
                    default: ;
                endcase
            end
            w_desc.mask[4] = 1'b1;
            w_desc.count   = n_count;
            w_desc.status  = n_err;
            n_mode  = M_IDLE;
            n_step  = 3'd0;
            n_start = 16'd0;
            n_len   = 16'd0;
            n_tok   = 1'b0;
            n_pos   = '0;
            n_count = 16'd0;
            n_err   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= MAX_TOK_RST;
            r_mode  <= M_IDLE;
            r_step  <= 3'd0;
            r_start <= 16'd0;
            r_len   <= 16'd0;
            r_tok   <= 1'b0;
            r_pos   <= '0;
            r_count <= 16'd0;
            r_err   <= ST_OK;
        end else begin
            if (i_cfg_we) r_max <= i_cfg_wdata;
            r_mode  <= n_mode;
            r_step  <= n_step;
            r_start <= n_start;
            r_len   <= n_len;
            r_tok   <= n_tok;
            r_pos   <= n_pos;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ltt_fifo.sv
// ----------------------------------------------------------------------------
// ltt_fifo
// Short queue of word bundles between scanner and word emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module ltt_fifo #(
    parameter int unsigned DEPTH = ltt_pkg::Q_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ltt_pkg::t_desc i_desc,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ltt_pkg::t_desc o_desc
);
    import ltt_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_desc         r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_desc  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_desc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count above depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> (r_wr == r_rd))
        else $error("pointers differ on empty queue");

endmodule

`default_nettype wire

FILE: hdl/ltt_back.sv
// ----------------------------------------------------------------------------
// ltt_back
// Word emitter: walks the slots of the head bundle into output words.
// ----------------------------------------------------------------------------
`default_nettype none

module ltt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  ltt_pkg::t_desc i_desc,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [3:0]     o_kind,
    output logic [15:0]    o_value,
    output logic [2:0]     o_status,
    output logic           o_last
);
    import ltt_pkg::*;

    logic [4:0]  r_taken, n_taken;
    logic        r_valid;
    t_kind       r_kind;
    logic [15:0] r_value;
    t_status     r_status;
    logic        r_last;

    logic [4:0]  w_rem, w_low;
    logic        w_fin, w_ld;
    t_kind       w_kind;
    logic [15:0] w_value;
    t_status     w_status;

    assign w_rem = i_desc.mask & ~r_taken;
    assign w_low = w_rem & (~w_rem + 5'd1);
    assign w_fin = ((w_rem & ~w_low) == 5'd0);
    assign w_ld  = !i_empty && (!r_valid || i_ready);
    assign o_pop = w_ld && w_fin;

    always_comb begin
        w_kind   = K_END;
        w_value  = 16'd0;
        w_status = ST_OK;
        case (w_low)
            5'b00001: w_kind = i_desc.kind0;
            5'b00010: begin
                w_kind  = K_NUMBER;
                w_value = i_desc.start;
            end
            5'b00100: begin
                w_kind  = K_NUMBER;
                w_value = i_desc.len;
            end
            5'b01000: w_kind = i_desc.kind3;
            5'b10000: begin
                w_kind   = K_END;
                w_value  = i_desc.count;
                w_status = i_desc.status;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_taken = r_taken;
        if (w_ld) n_taken = w_fin ? 5'd0 : (r_taken | w_low);
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_kind   <= w_kind;
            r_value  <= w_value;
            r_status <= w_status;
            r_last   <= w_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= 5'd0;
            r_valid <= 1'b0;
        end else begin
            r_taken <= n_taken;
            if (w_ld) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_kind   = r_kind;
    assign o_value  = r_value;
    assign o_status = r_status;
    assign o_last   = r_last;

    a_taken_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_taken == 5'd0))
        else $error("slot marks kept after bundle done");

endmodule

`default_nettype wire
